// ===== hw/rtl/key_sequence_toggle_detector_unit_assert.svh =====
// Assertion macros used by the checker file of the toggle detector.
`ifndef KEY_SEQUENCE_TOGGLE_DETECTOR_UNIT_ASSERT_SVH
`define KEY_SEQUENCE_TOGGLE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hw/rtl/ksd_pkg.sv =====
`default_nettype none

package ksd_pkg;

  // Width of the internal timestamp arithmetic; differences wrap at this width.
  localparam int TIME_BITS = 32;
  localparam int WIN_BITS  = 32;
  localparam int CMP_BITS  = 64;

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(300);

  // Key codes as they arrive on the input.
  localparam logic [1:0] CODE_OTHER = 2'd0;
  localparam logic [1:0] CODE_UP    = 2'd1;
  localparam logic [1:0] CODE_DOWN  = 2'd2;

  // Action codes of a result item.
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_OFF  = 2'd1;
  localparam logic [1:0] ACT_ON   = 2'd2;

  localparam logic [2:0] COUNT_MAX   = 3'd7;
  localparam logic [2:0] COUNT_GUARD = 3'd4;
  localparam logic [2:0] COUNT_ARM   = 3'd3;

  typedef enum logic [1:0] {
    EXP_NONE = 2'd0,
    EXP_UP   = 2'd1,
    EXP_DOWN = 2'd2
  } exp_key_t;

  typedef struct packed {
    logic                 is_key_event;
    logic [1:0]           key_code;
    logic                 pressed;
    logic [WIN_BITS-1:0]  now_ticks;
  } event_t;

  typedef struct packed {
    logic [1:0] action;
    logic       switch_level;
  } result_t;

  function automatic logic [2:0] count_inc(input logic [2:0] c);
    count_inc = (c == COUNT_MAX) ? COUNT_MAX : c + 3'd1;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ksd_in_stage.sv =====
`default_nettype none

module ksd_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire ksd_pkg::event_t in_item,
  input  wire logic            take,
  output logic                 full,
  output ksd_pkg::event_t      item
);
  import ksd_pkg::*;

  // The register empties only when the sequencer takes its item.
  assign in_stall = full & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ksd_seq_fsm.sv =====
`default_nettype none

module ksd_seq_fsm (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ksd_pkg::WIN_BITS-1:0]  cfg_wdata,
  input  wire logic                          step,
  input  wire ksd_pkg::event_t               item,
  output ksd_pkg::result_t                   result
);
  import ksd_pkg::*;

  logic [WIN_BITS-1:0]  window_ticks;
  logic [2:0]           press_count, press_count_next;
  exp_key_t             expected_key, expected_key_next;
  logic [TIME_BITS-1:0] last_press_time, last_press_time_next;
  logic                 switch_on, switch_on_next;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] gap;
  logic [1:0]           action;

  assign now_t = TIME_BITS'(item.now_ticks);
  assign gap   = now_t - last_press_time;

  always_comb begin
    press_count_next     = press_count;
    expected_key_next    = expected_key;
    last_press_time_next = last_press_time;
    switch_on_next       = switch_on;
    action               = ACT_NONE;
    if (step && item.is_key_event && item.pressed) begin
      // A stale sequence restarts before the key is looked at.
      if (CMP_BITS'(gap) > CMP_BITS'(window_ticks)) begin
        press_count_next     = 3'd0;
        last_press_time_next = now_t;
        expected_key_next    = EXP_NONE;
      end
      case (expected_key_next)
        EXP_NONE: begin
          if (item.key_code == CODE_UP && press_count_next < COUNT_GUARD) begin
            press_count_next     = 3'd1;
            last_press_time_next = now_t;
            expected_key_next    = EXP_UP;
          end
        end
        EXP_UP: begin
          if (item.key_code == CODE_UP) begin
            if (switch_on) begin
              switch_on_next = 1'b0;
              action         = ACT_OFF;
            end
            press_count_next  = COUNT_GUARD;
            expected_key_next = EXP_NONE;
          end else if (item.key_code == CODE_DOWN && press_count_next == COUNT_ARM) begin
            if (!switch_on) begin
              switch_on_next = 1'b1;
              action         = ACT_ON;
            end
            press_count_next  = COUNT_GUARD;
            expected_key_next = EXP_NONE;
          end else begin
            press_count_next  = count_inc(press_count_next);
            expected_key_next = EXP_DOWN;
          end
          last_press_time_next = now_t;
        end
        EXP_DOWN: begin
          if (item.key_code == CODE_UP) begin
            press_count_next  = count_inc(press_count_next);
            expected_key_next = EXP_UP;
          end else begin
            press_count_next  = 3'd0;
            expected_key_next = EXP_NONE;
          end
          last_press_time_next = now_t;
        end
        default: begin
        end
      endcase
    end
    result.action       = action;
    result.switch_level = switch_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks    <= WINDOW_RESET;
      press_count     <= 3'd0;
      expected_key    <= EXP_NONE;
      last_press_time <= '0;
      switch_on       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_ticks <= cfg_wdata;
      end
      press_count     <= press_count_next;
      expected_key    <= expected_key_next;
      last_press_time <= last_press_time_next;
      switch_on       <= switch_on_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ksd_out_stage.sv =====
`default_nettype none

module ksd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire ksd_pkg::result_t din,
  input  wire logic             out_stall,
  output logic                  ready,
  output logic                  out_valid,
  output ksd_pkg::result_t      dout
);
  import ksd_pkg::*;

  // Free when empty or when the held item leaves at this edge.
  assign ready = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      dout <= din;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/key_sequence_toggle_detector_unit.sv =====
// Path: an accepted item waits in the input register; its result is then
// loaded into the result register, from which it leaves on the output side.
// Throughput: one item per cycle when not stalled, one state update per item.
// Reset (rst, synchronous, active high): both stages empty, press count zero,
// no expected key, last press time zero, switch off, window back to 300 ticks.
`default_nettype none

// The block watches key press items and drives an on/off switch from
// volume-key sequences. An input register holds each accepted item; once the
// result register is free the sequencer applies the timeout check and the
// sequence rules to it, updating its state and loading the result register at
// the same edge. Every item yields exactly one result item.
//
// Flow control is a plain two-register pipeline. The result register is free
// when it is empty or its item leaves at this edge. The input register passes
// its item on exactly when the result register is free, so the input side is
// stalled only while a full input register waits behind a stalled result.
// A new item therefore enters in every cycle when the downstream side keeps up.
//
// The window register is written directly through cfg_we and cfg_wdata.
module key_sequence_toggle_detector_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ksd_pkg::WIN_BITS-1:0]  cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          is_key_event,
  input  wire logic [1:0]                    key_code,
  input  wire logic                          pressed,
  input  wire logic [ksd_pkg::WIN_BITS-1:0]  now_ticks,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         action,
  output logic                               switch_level
);
  import ksd_pkg::*;

  event_t  in_item;
  event_t  held_item;
  logic    held_full;
  logic    out_ready;
  logic    step;
  result_t step_result;
  result_t out_result;

  assign in_item.is_key_event = is_key_event;
  assign in_item.key_code     = key_code;
  assign in_item.pressed      = pressed;
  assign in_item.now_ticks    = now_ticks;

  // An item is processed when it sits in the input register and the result
  // register can take its result.
  assign step = held_full & out_ready;

  ksd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (out_ready),
    .full     (held_full),
    .item     (held_item)
  );

  ksd_seq_fsm u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (held_item),
    .result    (step_result)
  );

  ksd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .din       (step_result),
    .out_stall (out_stall),
    .ready     (out_ready),
    .out_valid (out_valid),
    .dout      (out_result)
  );

  assign action       = out_result.action;
  assign switch_level = out_result.switch_level;

endmodule

`default_nettype wire

// ===== hw/rtl/ksd_checker.sv =====
`default_nettype none
`include "key_sequence_toggle_detector_unit_assert.svh"

module ksd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] action,
  input wire logic       switch_level
);
  import ksd_pkg::*;

  logic [2:0] out_bits;

  assign out_bits = {action, switch_level};

  // An off action always leaves the switch off, an on action leaves it on.
  `KSD_ASSERT_IMP(a_off_level, clk, rst, out_valid && action == ACT_OFF, !switch_level)
  `KSD_ASSERT_IMP(a_on_level, clk, rst, out_valid && action == ACT_ON, switch_level)
  // The reserved action code is never produced.
  `KSD_ASSERT_IMP(a_action_code, clk, rst, out_valid, action <= ACT_ON)
  // A stalled result item holds.
  `KSD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_bits))

endmodule

bind key_sequence_toggle_detector_unit ksd_checker u_ksd_checker (.*);

`default_nettype wire

// ===== sim/key_sequence_toggle_detector_unit_test.sv =====
`default_nettype none

// Self-checking bench for the volume-key toggle detector.
//
// Items go in through a valid/stall channel and every accepted item yields
// exactly one result item on the output channel. A predictor in this module
// keeps its own copy of the sequence state (press count, expected key, time
// of the last accepted press, switch level and window) and works out the
// result of each item at the clock edge where the item is accepted. The
// expected results wait in a queue, and each result item that leaves the
// block is compared with the oldest of them.
//
// Both sides idle at random unless a test asks for a steady stream. Inputs
// are driven with nonblocking assignments just after a rising edge, and all
// handshakes are sampled at the rising edge, so every decision is made on
// the values that held before the edge.
module key_sequence_toggle_detector_unit_test;
  import ksd_pkg::*;

  // Key code three is not named by the package; the block treats it as any
  // other key.
  localparam logic [1:0] CODE_SPARE = 2'd3;

  localparam int IDLE_PERCENT  = 21;
  localparam int STALL_LIMIT   = 2000;
  // Wait after the last expected result has left the block, as a margin before
  // the block is treated as idle.
  localparam int SETTLE_CYCLES = 4;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                cfg_we       = 1'b0;
  logic [WIN_BITS-1:0] cfg_wdata    = '0;
  logic                in_valid     = 1'b0;
  logic                in_stall;
  logic                is_key_event = 1'b0;
  logic [1:0]          key_code     = CODE_OTHER;
  logic                pressed      = 1'b0;
  logic [WIN_BITS-1:0] now_ticks    = '0;
  logic                out_valid;
  logic                out_stall    = 1'b0;
  logic [1:0]          action;
  logic                switch_level;

  // Set by a test to switch off idling on both sides.
  bit no_idle = 1'b0;

  // Stimulus side: the window the block currently holds and the running
  // timestamp from which press times are drawn.
  logic [WIN_BITS-1:0] stim_window = WINDOW_RESET;
  logic [WIN_BITS-1:0] tick_clock  = '0;

  // Predicted sequence state.
  logic [2:0]          seq_count;
  exp_key_t            seq_want;
  logic [WIN_BITS-1:0] seq_last_press;
  logic [WIN_BITS-1:0] seq_window;
  logic                sw_on;

  result_t     pending_switch_results[$];
  int unsigned mismatches = 0;
  int          quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  key_sequence_toggle_detector_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .is_key_event (is_key_event),
    .key_code     (key_code),
    .pressed      (pressed),
    .now_ticks    (now_ticks),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .switch_level (switch_level)
  );

  // The press count stops at its maximum rather than wrapping.
  function automatic logic [2:0] bump_count(input logic [2:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 3'd1;
  endfunction

  // Applies one item to the predicted state and returns the result item it
  // should produce. Anything that is not a key press leaves the state alone.
  function automatic result_t advance_toggle_state(input logic ke, input logic [1:0] code,
                                                   input logic pr,
                                                   input logic [WIN_BITS-1:0] stamp);
    logic [WIN_BITS-1:0] gap;
    result_t             res;
    res.action = ACT_NONE;
    if (ke && pr) begin
      // The gap wraps with the timestamp, so a press just after the counter
      // rolls over is still close to one just before it.
      gap = stamp - seq_last_press;
      if (gap > seq_window) begin
        seq_count      = '0;
        seq_last_press = stamp;
        seq_want       = EXP_NONE;
      end
      case (seq_want)
        EXP_NONE: begin
          // After a toggle the count sits at the guard value, so a fresh
          // volume-up is refused until the window has run out.
          if (code == CODE_UP && seq_count < COUNT_GUARD) begin
            seq_count      = 3'd1;
            seq_last_press = stamp;
            seq_want       = EXP_UP;
          end
        end
        EXP_UP: begin
          if (code == CODE_UP) begin
            // Two ups in a row: off. Already off means no action, but the
            // sequence still ends.
            if (sw_on) begin
              sw_on      = 1'b0;
              res.action = ACT_OFF;
            end
            seq_count = COUNT_GUARD;
            seq_want  = EXP_NONE;
          end else if (code == CODE_DOWN && seq_count == COUNT_ARM) begin
            if (!sw_on) begin
              sw_on      = 1'b1;
              res.action = ACT_ON;
            end
            seq_count = COUNT_GUARD;
            seq_want  = EXP_NONE;
          end else begin
            // Any other key here, code three included, counts as a down.
            seq_count = bump_count(seq_count);
            seq_want  = EXP_DOWN;
          end
          seq_last_press = stamp;
        end
        EXP_DOWN: begin
          if (code == CODE_UP) begin
            seq_count = bump_count(seq_count);
            seq_want  = EXP_UP;
          end else begin
            seq_count = '0;
            seq_want  = EXP_NONE;
          end
          seq_last_press = stamp;
        end
        default: begin
        end
      endcase
    end
    res.switch_level = sw_on;
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [1:0] got, input logic [1:0] want);
    $display("%0t: %s is %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Scoreboard. Results are checked before the item accepted at the same
  // edge is predicted; a result can only belong to an item accepted at an
  // earlier edge, so the order never matters.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      seq_count      = '0;
      seq_want       = EXP_NONE;
      seq_last_press = '0;
      seq_window     = WINDOW_RESET;
      sw_on          = 1'b0;
      pending_switch_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_switch_results.size() == 0) begin
          flag_mismatch("action of a result item with nothing pending", action, ACT_NONE);
        end else begin
          want = pending_switch_results.pop_front();
          if (action !== want.action)
            flag_mismatch("action", action, want.action);
          if (switch_level !== want.switch_level)
            flag_mismatch("switch_level", switch_level, want.switch_level);
        end
      end
      if (cfg_we)
        seq_window = cfg_wdata;
      if (in_valid && !in_stall)
        pending_switch_results.push_back(
          advance_toggle_state(is_key_event, key_code, pressed, now_ticks));
    end
  end

  // The receiving side stalls at random unless a steady stream is wanted.
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // Watchdog: ends the run if no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog expired, no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and returns at the edge where it is accepted. Valid is
  // left high so that a following item can go out back to back; it is only
  // lowered when the sender decides to idle or waits for the block to drain.
  task automatic send_key_item(input logic ke, input logic [1:0] code, input logic pr,
                               input logic [WIN_BITS-1:0] stamp);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    is_key_event <= ke;
    key_code     <= code;
    pressed      <= pr;
    now_ticks    <= stamp;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
  endtask

  task automatic send_press(input logic [1:0] code, input logic [WIN_BITS-1:0] stamp);
    send_key_item(1'b1, code, 1'b1, stamp);
  endtask

  // Holds the sender back until every expected result has left the block.
  // The queue is looked at on falling edges, away from the scoreboard.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_switch_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The window is only written once the block has gone quiet.
  task automatic write_window(input logic [WIN_BITS-1:0] value);
    wait_for_drain();
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    stim_window  = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Moves the running timestamp on, either within the window or past it.
  task automatic advance_clock(input bit beyond);
    longint unsigned step;
    if (beyond && stim_window != '1)
      step = longint'(stim_window) + 64'd1 + 64'($urandom_range(0, 40));
    else
      step = 64'($urandom_range(0, stim_window));
    if (step > 64'hFFFF_FFFF)
      step = 64'(stim_window);
    tick_clock = tick_clock + step[WIN_BITS-1:0];
  endtask

  // Random traffic. Most of it is made of the two real gestures and of short
  // random key runs with plausible gaps, so that the deeper states are
  // reached; the rest is noise with arbitrary fields and timestamps.
  task automatic run_traffic(input int unsigned presses);
    int unsigned         sent;
    int unsigned         pick;
    logic [1:0]          burst[$];
    logic                ke;
    logic                pr;
    logic [WIN_BITS-1:0] stamp;
    sent = 0;
    while (sent < presses) begin
      pick = $urandom_range(0, 99);
      burst.delete();
      if (pick < 15) begin
        ke    = 1'($urandom_range(0, 1));
        pr    = 1'($urandom_range(0, 1));
        stamp = $urandom;
        if (ke && pr) begin
          tick_clock = stamp;
          sent++;
        end
        send_key_item(ke, 2'($urandom_range(0, 3)), pr, stamp);
      end else begin
        if (pick < 40) begin
          burst = '{CODE_UP, CODE_UP};
        end else if (pick < 70) begin
          burst = '{CODE_UP, CODE_DOWN, CODE_UP, CODE_DOWN};
          if ($urandom_range(0, 99) < 25)
            burst[$urandom_range(1, 3)] = $urandom_range(0, 1) ? CODE_OTHER : CODE_SPARE;
        end else begin
          repeat ($urandom_range(1, 8)) burst.push_back(2'($urandom_range(0, 3)));
        end
        foreach (burst[i]) begin
          // A burst starts after the window has lapsed about half the time, which
          // also lets the guard after a toggle run out.
          advance_clock((i == 0) ? ($urandom_range(0, 99) < 50) : ($urandom_range(0, 99) < 5));
          if ($urandom_range(0, 99) < 12)
            send_key_item(1'b1, burst[i], 1'b0, tick_clock);
          if ($urandom_range(0, 99) < 8)
            send_key_item(1'b0, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          $urandom);
          send_press(burst[i], tick_clock);
          sent++;
        end
      end
    end
  endtask

  // Items that are ignored, the off and on gestures, a redundant off and the
  // guard that follows a toggle.
  task automatic test_ignored_and_toggles();
    send_key_item(1'b0, CODE_UP, 1'b1, 32'd10);
    send_key_item(1'b1, CODE_UP, 1'b0, 32'd10);
    send_press(CODE_UP, 32'd20);
    send_press(CODE_UP, 32'd30);     // off while already off
    send_press(CODE_UP, 32'd40);     // refused by the guard
    send_press(CODE_UP, 32'd400);    // window lapsed, sequence restarts
    send_press(CODE_DOWN, 32'd410);
    send_press(CODE_UP, 32'd420);
    send_press(CODE_DOWN, 32'd430);  // switch on
    send_press(CODE_UP, 32'd800);
    send_press(CODE_UP, 32'd810);    // switch off
  endtask

  // Other keys and code three standing in for a down, and the press count
  // pinned at its maximum in both expected-key states.
  task automatic test_odd_keys_and_saturation();
    send_press(CODE_UP, 32'd1200);
    send_press(CODE_SPARE, 32'd1210);
    send_press(CODE_UP, 32'd1220);
    send_press(CODE_OTHER, 32'd1230);
    send_press(CODE_UP, 32'd1240);
    send_press(CODE_OTHER, 32'd1250);
    send_press(CODE_UP, 32'd1260);
    send_press(CODE_DOWN, 32'd1270);
    send_press(CODE_UP, 32'd1280);
    send_press(CODE_OTHER, 32'd1290);
  endtask

  // The on gesture spread across a rollover of the timestamp.
  task automatic test_timestamp_wrap();
    send_press(CODE_UP, 32'hFFFF_FFC0);
    send_press(CODE_DOWN, 32'hFFFF_FFE0);
    send_press(CODE_UP, 32'h0000_0010);
    send_press(CODE_DOWN, 32'h0000_0040);
  endtask

  // A window of one tick, where a gap of two ticks already restarts, and the
  // largest, where nothing ever times out.
  task automatic test_window_extremes();
    write_window(32'd1);
    send_press(CODE_UP, 32'h41);
    send_press(CODE_UP, 32'h43);
    send_press(CODE_UP, 32'h44);
    send_press(CODE_UP, 32'h46);
    send_press(CODE_DOWN, 32'h47);
    send_press(CODE_UP, 32'h49);
    write_window('1);
    send_press(CODE_UP, 32'h05);
    send_press(CODE_UP, 32'hFFFF_FFFF);
    send_key_item(1'b0, CODE_SPARE, 1'b0, 32'h0);
  endtask

  task automatic test_random_sequences();
    tick_clock = $urandom;
    write_window(WINDOW_RESET);
    run_traffic(240);
    write_window(32'd1);
    run_traffic(100);
    write_window($urandom_range(2, 2000));
    run_traffic(200);
    write_window($urandom);
    run_traffic(80);
    write_window('1);
    run_traffic(50);
  endtask

  // Neither side idles, so items go through at the full rate.
  task automatic test_steady_stream();
    write_window(32'd37);
    no_idle = 1'b1;
    run_traffic(160);
    wait_for_drain();
    no_idle = 1'b0;
  endtask

  // Short runs with the sender waiting for the block to empty after each.
  task automatic test_pause_until_drained();
    write_window($urandom_range(50, 500));
    repeat (4) begin
      run_traffic(25);
      wait_for_drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_ignored_and_toggles();
    test_odd_keys_and_saturation();
    test_timestamp_wrap();
    test_window_extremes();
    test_random_sequences();
    test_steady_stream();
    test_pause_until_drained();
    wait_for_drain();
    if (mismatches == 0 && pending_switch_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
